>>> sv/chsi_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the cubic/Hermite sample interpolator.
package chsi_pkg;

  localparam int QBITS     = 14;          // tension and bias are Q1.14
  localparam int COEF_W    = QBITS + 3;   // holds 1 +/- bias and 1 - tension
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int LATENCY   = 9;           // request to result, in clock cycles

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TENSION = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_BIAS    = 2'd2;

  localparam logic signed [COEF_W-1:0] Q_ONE = COEF_W'(1 << QBITS);
  localparam logic signed [COEF_W-1:0] Q_TWO = COEF_W'(2 << QBITS);

  typedef enum logic {
    MODE_CUBIC   = 1'b0,
    MODE_HERMITE = 1'b1
  } interp_mode_t;

endpackage

>>> sv/cubic_hermite_sample_interpolator_core.sv
`timescale 1ns / 1ps
// Four-point cubic / Hermite interpolator: a pipeline of narrow multiplier stages.
//
// One request per clock: start is taken whenever busy is low, and busy is high only
// around reset. Each request gives one result, marked by a one-cycle out_valid; results
// cannot be held off. The result passes through a chain of registered multiplier stages
// (coefficient products, tangent sums, the f*g*(D0*g - D1*f) term split into partial
// products, final sum and rounding, saturation). Write the configuration registers only
// while no request is in flight.
module cubic_hermite_sample_interpolator_core
  import chsi_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_W-1:0]              cfg_data,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_prev,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_start,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_end,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_next,
  input  logic [FRAC_BITS-1:0]          in_frac_pos,
  output logic                          out_valid,
  output logic signed [SAMPLE_BITS-1:0] out_interp_value,
  output logic                          out_clipped
);

  localparam int S    = SAMPLE_BITS;
  localparam int F    = FRAC_BITS;
  localparam int DW   = S + 1;              // sample differences
  localparam int PPW  = DW + COEF_W;
  localparam int DDW  = PPW + 1;            // tangent numerators D0, D1
  localparam int FW   = F + 1;              // f as signed
  localparam int GW   = F + 2;              // g = 1 - f
  localparam int HW   = F + 3;              // h = 3 - 2f
  localparam int FGW  = FW + GW;
  localparam int F2W  = 2 * FW;
  localparam int GFGW = COEF_W + FGW;
  localparam int VW   = DW + F2W;
  localparam int VL   = VW / 2;
  localparam int VH   = VW - VL;
  localparam int YLW  = VL + 1 + HW;
  localparam int YHW  = VH + HW;
  localparam int YW   = VW + HW + 1;
  localparam int AW   = DDW + GW;
  localparam int BW   = DDW + FW;
  localparam int EW   = AW + 1;
  localparam int EL   = EW / 2;
  localparam int EH   = EW - EL;
  localparam int GL   = GFGW / 2;
  localparam int GH   = GFGW - GL;
  localparam int LLW  = EL + GL + 2;
  localparam int LHW  = EL + 1 + GH;
  localparam int HLW  = EH + GL + 1;
  localparam int HHW  = EH + GH;
  localparam int SHW  = EH + GFGW + 1;
  localparam int SLW  = EL + GFGW + 2;
  localparam int KSH  = 2 * QBITS + 1;
  localparam int ZW   = EW + GFGW + 2;
  localparam int PW   = ((ZW > YW + KSH) ? ZW : YW + KSH) + 2;
  localparam int RSH  = 3 * F + KSH;
  localparam int RW   = PW - RSH;

  localparam logic signed [GW-1:0] FRAC_ONE   = {2'b01, {F{1'b0}}};
  localparam logic signed [HW-1:0] FRAC_THREE = {3'b011, {F{1'b0}}};
  localparam logic signed [PW-1:0] P_HALF     = {{(PW-RSH){1'b0}}, 1'b1, {(RSH-1){1'b0}}};
  localparam logic signed [RW-1:0] R_MAX      = {{(RW-S+1){1'b0}}, {(S-1){1'b1}}};
  localparam logic signed [RW-1:0] R_MIN      = {{(RW-S+1){1'b1}}, {(S-1){1'b0}}};
  localparam logic signed [S-1:0]  OUT_MAX    = {1'b0, {(S-1){1'b1}}};
  localparam logic signed [S-1:0]  OUT_MIN    = {1'b1, {(S-1){1'b0}}};

  // configuration
  interp_mode_t             interp_mode_r;
  logic signed [CFG_W-1:0]  tension_r;
  logic signed [CFG_W-1:0]  bias_r;

  // control
  logic                     busy_r;
  logic [LATENCY-2:0]       vld_r;
  logic                     out_valid_r;
  logic                     in_accept;

  // stage 1
  logic signed [S-1:0]      y1_s1_r;
  logic signed [DW-1:0]     d0_r, d1_r, d2_r;
  logic signed [COEF_W-1:0] wp_r, wm_r, gt_r;
  logic signed [FW-1:0]     f_s1_r;
  logic signed [GW-1:0]     g_s1_r;
  logic signed [HW-1:0]     h_s1_r;
  logic signed [DW-1:0]     d0_nxt, d1_nxt, d2_nxt;
  logic signed [COEF_W-1:0] wp_nxt, wm_nxt, gt_nxt;
  logic signed [FW-1:0]     f_nxt;
  logic signed [GW-1:0]     g_nxt;
  logic signed [HW-1:0]     h_nxt;

  // stage 2
  logic signed [PPW-1:0]    p00_r, p11_r, p10_r, p21_r;
  logic signed [FGW-1:0]    fg_r;
  logic signed [F2W-1:0]    f2_r;
  logic signed [S-1:0]      y1_s2_r;
  logic signed [DW-1:0]     d1_s2_r;
  logic signed [COEF_W-1:0] gt_s2_r;
  logic signed [FW-1:0]     f_s2_r;
  logic signed [GW-1:0]     g_s2_r;
  logic signed [HW-1:0]     h_s2_r;

  // stage 3
  logic signed [DDW-1:0]    dd0_r, dd1_r;
  logic signed [GFGW-1:0]   gfg_r;
  logic signed [VW-1:0]     v_r;
  logic signed [S-1:0]      y1_s3_r;
  logic signed [FW-1:0]     f_s3_r;
  logic signed [GW-1:0]     g_s3_r;
  logic signed [HW-1:0]     h_s3_r;

  // stage 4
  logic signed [AW-1:0]     a_r;
  logic signed [BW-1:0]     b_r;
  logic signed [YLW-1:0]    yl_r;
  logic signed [YHW-1:0]    yh_r;
  logic signed [S-1:0]      y1_s4_r;
  logic signed [GFGW-1:0]   gfg_s4_r;

  // stage 5
  logic signed [EW-1:0]     e_r;
  logic signed [YW-1:0]     y_r;
  logic signed [GFGW-1:0]   gfg_s5_r;

  // stage 6
  logic signed [LLW-1:0]    pll_r;
  logic signed [LHW-1:0]    plh_r;
  logic signed [HLW-1:0]    phl_r;
  logic signed [HHW-1:0]    phh_r;
  logic signed [YW-1:0]     y_s6_r;

  // stage 7
  logic signed [SHW-1:0]    shi_r;
  logic signed [SLW-1:0]    slo_r;
  logic signed [YW-1:0]     y_s7_r;

  // stage 8
  logic signed [PW-1:0]     p_r;

  // output
  logic signed [RW-1:0]     r_val;
  logic signed [S-1:0]      value_nxt;
  logic                     clip_nxt;
  logic signed [S-1:0]      value_r;
  logic                     clip_r;

  assign in_accept = start & ~busy_r;

  // Cubic mode is Hermite with tangents y2-y0 and y3-y1: unit bias weights, G = 2.
  always_comb begin
    d0_nxt = DW'(in_sample_start) - DW'(in_sample_prev);
    d1_nxt = DW'(in_sample_end) - DW'(in_sample_start);
    d2_nxt = DW'(in_sample_next) - DW'(in_sample_end);
    f_nxt  = $signed({1'b0, in_frac_pos});
    g_nxt  = FRAC_ONE - GW'(f_nxt);
    h_nxt  = FRAC_THREE - (HW'(f_nxt) <<< 1);
    if (interp_mode_r == MODE_HERMITE) begin
      wp_nxt = Q_ONE + COEF_W'(bias_r);
      wm_nxt = Q_ONE - COEF_W'(bias_r);
      gt_nxt = Q_ONE - COEF_W'(tension_r);
    end else begin
      wp_nxt = Q_ONE;
      wm_nxt = Q_ONE;
      gt_nxt = Q_TWO;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interp_mode_r <= MODE_HERMITE;
      tension_r     <= '0;
      bias_r        <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_MODE:    interp_mode_r <= interp_mode_t'(cfg_data[0]);
        CFG_IDX_TENSION: tension_r     <= $signed(cfg_data);
        CFG_IDX_BIAS:    bias_r        <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= 1'b0;
      vld_r       <= {vld_r[LATENCY-3:0], in_accept};
      out_valid_r <= vld_r[LATENCY-2];
    end
  end

  // datapath: P = 2^29 * Y + G * f*g*(D0*g - D1*f), all over 2^(3F+29)
  always_ff @(posedge clk) begin
    y1_s1_r  <= in_sample_start;
    d0_r     <= d0_nxt;
    d1_r     <= d1_nxt;
    d2_r     <= d2_nxt;
    wp_r     <= wp_nxt;
    wm_r     <= wm_nxt;
    gt_r     <= gt_nxt;
    f_s1_r   <= f_nxt;
    g_s1_r   <= g_nxt;
    h_s1_r   <= h_nxt;

    p00_r    <= d0_r * wp_r;
    p11_r    <= d1_r * wm_r;
    p10_r    <= d1_r * wp_r;
    p21_r    <= d2_r * wm_r;
    fg_r     <= f_s1_r * g_s1_r;
    f2_r     <= f_s1_r * f_s1_r;
    y1_s2_r  <= y1_s1_r;
    d1_s2_r  <= d1_r;
    gt_s2_r  <= gt_r;
    f_s2_r   <= f_s1_r;
    g_s2_r   <= g_s1_r;
    h_s2_r   <= h_s1_r;

    dd0_r    <= DDW'(p00_r) + DDW'(p11_r);
    dd1_r    <= DDW'(p10_r) + DDW'(p21_r);
    gfg_r    <= gt_s2_r * fg_r;
    v_r      <= d1_s2_r * f2_r;
    y1_s3_r  <= y1_s2_r;
    f_s3_r   <= f_s2_r;
    g_s3_r   <= g_s2_r;
    h_s3_r   <= h_s2_r;

    a_r      <= dd0_r * g_s3_r;
    b_r      <= dd1_r * f_s3_r;
    yl_r     <= $signed({1'b0, v_r[VL-1:0]}) * h_s3_r;
    yh_r     <= $signed(v_r[VW-1:VL]) * h_s3_r;
    y1_s4_r  <= y1_s3_r;
    gfg_s4_r <= gfg_r;

    e_r      <= EW'(a_r) - EW'(b_r);
    y_r      <= (YW'(y1_s4_r) <<< (3 * F)) + (YW'(yh_r) <<< VL) + YW'(yl_r);
    gfg_s5_r <= gfg_s4_r;

    // split both wide operands into an unsigned low half and a signed high half
    pll_r    <= $signed({1'b0, e_r[EL-1:0]}) * $signed({1'b0, gfg_s5_r[GL-1:0]});
    plh_r    <= $signed({1'b0, e_r[EL-1:0]}) * $signed(gfg_s5_r[GFGW-1:GL]);
    phl_r    <= $signed(e_r[EW-1:EL]) * $signed({1'b0, gfg_s5_r[GL-1:0]});
    phh_r    <= $signed(e_r[EW-1:EL]) * $signed(gfg_s5_r[GFGW-1:GL]);
    y_s6_r   <= y_r;

    shi_r    <= (SHW'(phh_r) <<< GL) + SHW'(phl_r);
    slo_r    <= (SLW'(plh_r) <<< GL) + SLW'(pll_r);
    y_s7_r   <= y_s6_r;

    p_r      <= (PW'(shi_r) <<< EL) + PW'(slo_r) + (PW'(y_s7_r) <<< KSH) + P_HALF;

    value_r  <= value_nxt;
    clip_r   <= clip_nxt;
  end

  // round-half-up already added; drop the fraction and saturate
  always_comb begin
    r_val = $signed(p_r[PW-1:RSH]);
    if (r_val > R_MAX) begin
      value_nxt = OUT_MAX;
      clip_nxt  = 1'b1;
    end else if (r_val < R_MIN) begin
      value_nxt = OUT_MIN;
      clip_nxt  = 1'b1;
    end else begin
      value_nxt = $signed(r_val[S-1:0]);
      clip_nxt  = 1'b0;
    end
  end

  assign busy             = busy_r;
  assign out_valid        = out_valid_r;
  assign out_interp_value = value_r;
  assign out_clipped      = clip_r;

endmodule

>>> sv/chsi_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the interpolator core, bound into every instance of the core module.
module chsi_checker
  import chsi_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int FRAC_BITS   = 16
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic signed [SAMPLE_BITS-1:0] in_sample_start,
  input logic [FRAC_BITS-1:0]          in_frac_pos,
  input logic                          out_valid,
  input logic signed [SAMPLE_BITS-1:0] out_interp_value,
  input logic                          out_clipped
);

  localparam logic signed [SAMPLE_BITS-1:0] V_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] V_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // every result traces back to a request a fixed latency earlier
  a_out_from_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result without a matching request");

  a_req_gives_out: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("request lost");

  a_busy_only_in_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !busy)
    else $error("busy outside reset");

  a_clip_at_rail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_clipped) |-> (out_interp_value == V_MAX || out_interp_value == V_MIN))
    else $error("clipped result not at a rail");

  // at position zero the result is the interval start sample, exactly
  a_frac_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(in_frac_pos, LATENCY) == '0) |->
      (out_interp_value == $past(in_sample_start, LATENCY) && !out_clipped))
    else $error("zero position does not return the start sample");

endmodule

bind cubic_hermite_sample_interpolator_core chsi_checker #(
  .SAMPLE_BITS(SAMPLE_BITS),
  .FRAC_BITS  (FRAC_BITS)
) u_chsi_checker (.*);
